FILE: hdl/sfnc_pkg.sv
package sfnc_pkg;

    // Register file
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 10;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXT_ENABLE = 1'd1;
    localparam logic [7:0] MAX_LENGTH_RESET = 8'd128;
    localparam logic [9:0] EXT_ENABLE_RESET = 10'd1023;

    // Name tracking
    localparam int unsigned EXT_COUNT = 10;
    localparam int unsigned WINDOW    = 5;
    localparam logic [2:0]  STEM_KEEP = 3'd4;
    localparam logic [2:0]  STEM_SAT  = 3'd5;

    typedef enum logic [2:0] {
        REF_OK        = 3'd0,
        REF_TOO_LONG  = 3'd1,
        REF_SEPARATOR = 3'd2,
        REF_LEAD_DOT  = 3'd3,
        REF_TRAIL     = 3'd4,
        REF_BAD       = 3'd5,
        REF_EXT       = 3'd6
    } t_refusal;

    // Absorbed view of a name after the current byte
    typedef struct packed {
        logic [7:0]       byte_count;
        logic [3:0][7:0]  stem;
        logic [2:0]       stem_len;
        logic [4:0][7:0]  window;
        logic             separator_seen;
        logic             bad_byte_seen;
        logic             starts_with_dot;
    } t_track;

    typedef logic [39:0] t_ext_text;

    // Extensions, right aligned: json png jpg jpeg webp gif bmp xml txt svg
    localparam t_ext_text EXT_TEXT [EXT_COUNT] = '{
        40'(".json"), 40'(".png"), 40'(".jpg"), 40'(".jpeg"), 40'(".webp"),
        40'(".gif"),  40'(".bmp"), 40'(".xml"), 40'(".txt"),  40'(".svg")
    };
    localparam logic [EXT_COUNT-1:0] EXT_IS_FIVE = 10'b00_0001_1001;

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        fold_lower = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

endpackage

FILE: hdl/sfnc_name_if.sv
interface sfnc_name_if import sfnc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] name_byte;
    logic       is_last;

    modport source (output valid, output name_byte, output is_last, input ready);
    modport sink (input valid, input name_byte, input is_last, output ready);
endinterface

FILE: hdl/sfnc_verdict_if.sv
interface sfnc_verdict_if import sfnc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       is_safe;
    logic [2:0] refusal_code;

    modport source (output valid, output is_safe, output refusal_code, input ready);
    modport sink (input valid, input is_safe, input refusal_code, output ready);
endinterface

FILE: hdl/sfnc_tracker.sv
module sfnc_tracker import sfnc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_track     o_track
);

    t_track r_track;
    t_track n_track;
    logic   r_dot_seen;
    logic   n_dot_seen;
    logic [7:0] lc;
    logic       allowed;

    // Absorb the byte into the running view
    always_comb begin
        lc = fold_lower(i_byte);
        allowed = (i_byte >= "0" && i_byte <= "9") || (i_byte >= "a" && i_byte <= "z") ||
                  (i_byte >= "A" && i_byte <= "Z") || i_byte == "." || i_byte == "_" ||
                  i_byte == "-";
        n_track = r_track;
        n_dot_seen = r_dot_seen;
        if (r_track.byte_count == 8'd0 && i_byte == ".") begin
            n_track.starts_with_dot = 1'b1;
        end
        if (r_track.byte_count != 8'd255) begin
            n_track.byte_count = r_track.byte_count + 8'd1;
        end
        if (i_byte == "/" || i_byte == "\\" || i_byte == ":") begin
            n_track.separator_seen = 1'b1;
        end
        if (!allowed) begin
            n_track.bad_byte_seen = 1'b1;
        end
        if (!r_dot_seen) begin
            if (i_byte == ".") begin
                n_dot_seen = 1'b1;
            end else begin
                if (r_track.stem_len < STEM_KEEP) begin
                    n_track.stem[r_track.stem_len[1:0]] = lc;
                end
                if (r_track.stem_len < STEM_SAT) begin
                    n_track.stem_len = r_track.stem_len + 3'd1;
                end
            end
        end
        n_track.window = {lc, r_track.window[4:1]};
    end

    // Hold between bytes, clear after the last byte of a name
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track    <= '0;
            r_dot_seen <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_track    <= '0;
                r_dot_seen <= 1'b0;
            end else begin
                r_track    <= n_track;
                r_dot_seen <= n_dot_seen;
            end
        end
    end

    assign o_track = n_track;

endmodule

FILE: hdl/sfnc_judge.sv
module sfnc_judge import sfnc_pkg::*; (
    input  t_track     i_track,
    input  logic [7:0] i_last_byte,
    input  logic [7:0] i_max_length,
    input  logic [9:0] i_ext_enable,
    output t_refusal   o_code
);

    logic [23:0] stem3;
    logic        reserved;
    logic [39:0] tail5;
    logic [EXT_COUNT-1:0] ext_hit;

    // Match the stem against device names
    always_comb begin
        stem3 = {i_track.stem[0], i_track.stem[1], i_track.stem[2]};
        reserved = 1'b0;
        if (i_track.stem_len == 3'd3) begin
            reserved = stem3 == "con" || stem3 == "prn" || stem3 == "aux" ||
                       stem3 == "nul";
        end else if (i_track.stem_len == 3'd4) begin
            reserved = (stem3 == "com" || stem3 == "lpt") &&
                       i_track.stem[3] >= "1" && i_track.stem[3] <= "9";
        end
    end

    // Compare the tail against each enabled extension in parallel
    always_comb begin
        tail5 = {i_track.window[0], i_track.window[1], i_track.window[2],
                 i_track.window[3], i_track.window[4]};
        for (int e = 0; e < EXT_COUNT; e++) begin
            if (EXT_IS_FIVE[e]) begin
                ext_hit[e] = i_ext_enable[e] && i_track.byte_count >= 8'd5 &&
                             tail5 == EXT_TEXT[e];
            end else begin
                ext_hit[e] = i_ext_enable[e] && i_track.byte_count >= 8'd4 &&
                             tail5[31:0] == EXT_TEXT[e][31:0];
            end
        end
    end

    // Pick the first refusal in priority order
    always_comb begin
        if (i_track.byte_count > i_max_length) begin
            o_code = REF_TOO_LONG;
        end else if (i_track.separator_seen) begin
            o_code = REF_SEPARATOR;
        end else if (i_track.starts_with_dot) begin
            o_code = REF_LEAD_DOT;
        end else if (i_last_byte == "." || i_last_byte == " ") begin
            o_code = REF_TRAIL;
        end else if (i_track.bad_byte_seen || reserved) begin
            o_code = REF_BAD;
        end else if (ext_hit == '0) begin
            o_code = REF_EXT;
        end else begin
            o_code = REF_OK;
        end
    end

endmodule

FILE: hdl/safe_file_name_checker_core.sv
// A name's last byte passes the input register, then its verdict is held in the verdict register.
// Throughput: one name byte per cycle; the byte register and the verdict register
// let bytes keep flowing while a verdict waits, only a second last byte stalls.
// Reset (synchronous, active low): name state and both registers empty,
// max_length 128, extension_enable all ones.
module safe_file_name_checker_core import sfnc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    sfnc_name_if.sink              i_name,
    sfnc_verdict_if.source         o_verdict,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [7:0] r_max_length;
    logic [9:0] r_ext_enable;

    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;
    logic       r_out_valid;
    logic       r_out_safe;
    t_refusal   r_out_code;

    logic       out_free;
    logic       s1_move;
    logic       in_take;
    t_track     track;
    t_refusal   code;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RESET;
            r_ext_enable <= EXT_ENABLE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_LENGTH: r_max_length <= i_cfg_data[7:0];
                CFG_EXT_ENABLE: r_ext_enable <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Flow control: a byte leaves the input register unless it is a last byte
    // facing a full verdict register
    assign out_free = !r_out_valid || o_verdict.ready;
    assign s1_move  = r_s1_valid && (!r_s1_last || out_free);
    assign i_name.ready = !r_s1_valid || s1_move;
    assign in_take  = i_name.valid && i_name.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_name.ready) begin
            r_s1_valid <= i_name.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_byte <= i_name.name_byte;
            r_s1_last <= i_name.is_last;
        end
    end

    sfnc_tracker u_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s1_move),
        .i_byte  (r_s1_byte),
        .i_last  (r_s1_last),
        .o_track (track)
    );

    sfnc_judge u_judge (
        .i_track      (track),
        .i_last_byte  (r_s1_byte),
        .i_max_length (r_max_length),
        .i_ext_enable (r_ext_enable),
        .o_code       (code)
    );

    // Verdict register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_move && r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s1_move && r_s1_last) begin
            r_out_safe <= code == REF_OK;
            r_out_code <= code;
        end
    end

    assign o_verdict.valid        = r_out_valid;
    assign o_verdict.is_safe      = r_out_safe;
    assign o_verdict.refusal_code = r_out_code;

    // Checks
    a_safe_matches_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_verdict.valid |-> (o_verdict.is_safe == (o_verdict.refusal_code == REF_OK)))
        else $error("is_safe disagrees with refusal_code");

    a_code_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_verdict.valid |-> (o_verdict.refusal_code <= REF_EXT))
        else $error("refusal_code out of range");

    a_last_gives_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && r_s1_last) |=> r_out_valid)
        else $error("last byte moved without a verdict");

    a_stalled_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last && r_out_valid && !o_verdict.ready) |-> !i_name.ready)
        else $error("input taken over a stalled last byte");

endmodule
